/* rtl/core/hpid_pkg.sv */
`default_nettype none
package hpid_pkg;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [14:0] heading;
		logic [14:0] target_heading;
	} hpid_in_t;

	typedef struct packed {
		logic signed [16:0] turn_rate;
		logic [1:0]         mode;
	} hpid_out_t;

	// register indexes
	localparam logic [2:0] REG_GAIN_P    = 3'd0;
	localparam logic [2:0] REG_GAIN_I    = 3'd1;
	localparam logic [2:0] REG_GAIN_D    = 3'd2;
	localparam logic [2:0] REG_GYBE_THR  = 3'd3;
	localparam logic [2:0] REG_GYBE_TMO  = 3'd4;

	// steering modes
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_POT    = 2'd1;
	localparam logic [1:0] MODE_GYBE   = 2'd2;

	// angles in 1/64 degree
	localparam logic [14:0] FULL_CIRCLE = 15'd23040;
	localparam logic [14:0] HALF_CIRCLE = 15'd11520;
	localparam logic signed [15:0] RESET_ANGLE = 16'sd2880;
	localparam logic signed [15:0] ERR_LIMIT   = 16'sd5760;
	localparam logic [31:0] MIN_DT_MS = 32'd50;
	localparam logic signed [55:0] TR_LIMIT = 56'sd40960;
	localparam logic [38:0] ICLAMP_NUM = 39'd419430400000;
	// ceil(2^36 / 1000), exact floor(v / 1000) for v < 2^26
	localparam logic [26:0] RECIP_1000 = 27'd68719477;

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_ERR     = 14'b00000000000010,
		S_MUL_E   = 14'b00000000000100,
		S_SUM     = 14'b00000000001000,
		S_DIV_R   = 14'b00000000010000,
		S_DIV_L   = 14'b00000000100000,
		S_CLAMP_I = 14'b00000001000000,
		S_MUL_P   = 14'b00000010000000,
		S_MUL_D   = 14'b00000100000000,
		S_MUL_ILO = 14'b00001000000000,
		S_MUL_IHI = 14'b00010000000000,
		S_ITERM   = 14'b00100000000000,
		S_DIV_I   = 14'b01000000000000,
		S_OUT     = 14'b10000000000000
	} hpid_state_t;

endpackage
`default_nettype wire

/* rtl/core/heading_pid_with_gybe_mode.sv */
`default_nettype none
// channel   dir  handshake            word
// in        in   in_valid / in_stall  hpid_in_t  (now_ms, heading, target_heading)
// out       out  out_valid / out_stall hpid_out_t (turn_rate, mode)
// cfg       in   cfg_we               cfg_index, cfg_data (32 bit)
//
// A word keeps in_stall high from its accept edge until its result is loaded: the
// rate divide (restoring, one quotient bit per cycle), the integral limit divide
// and clamp (only when gain_i > 0) and the integral term's divide by 1000 (four
// 16-bit digits by reciprocal multiply, skipped when the term saturates) run
// between fixed steps. A word with dt < 50 ms is dropped in its accept cycle.
// The result sits in an output register; out_stall only holds the final step.
// Reset restores the register defaults and clears all controller state.
module heading_pid_with_gybe_mode
	import hpid_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire hpid_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output hpid_out_t        out_data,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	// shortest signed distance from o to t on the wrapped circle
	function automatic logic signed [15:0] wrap_dist(input logic [14:0] o,
			input logic [14:0] t);
		logic [14:0] raw;
		logic [14:0] m;
		logic [14:0] mag;
		logic        neg;
		raw = (o > t) ? (o - t) : (t - o);
		m   = (raw >= FULL_CIRCLE) ? (raw - FULL_CIRCLE) : raw;
		if (m > HALF_CIRCLE) begin
			mag = FULL_CIRCLE - m;
			neg = (t > o);
		end else begin
			mag = m;
			neg = (o > t);
		end
		wrap_dist = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	hpid_state_t state_q;

	// config
	logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
	logic [13:0]        thr_q;
	logic [31:0]        tmo_q;

	// controller state
	logic [31:0]        last_q;
	logic signed [47:0] integral_q;
	logic signed [31:0] rate_q;
	logic signed [13:0] prev_err_q;
	logic [14:0]        prev_hd_q;
	logic [31:0]        gstart_q;
	logic               gpos_q;
	logic [1:0]         mode_q;

	// per-word work registers
	logic [31:0]        now_q, dt_q;
	logic [14:0]        hd_q, tgt_q;
	logic signed [13:0] err_q;
	logic [1:0]         nmode_q;
	logic               rneg_q;
	logic [38:0]        lim_q;
	logic signed [65:0] prod_q;
	logic [55:0]        plo_q;
	logic signed [55:0] acc_q;
	logic               ineg_q;

	// divider
	logic [52:0] dq_q;
	logic [31:0] rem_q;
	logic [31:0] div_d_q;
	logic [5:0]  cnt_q;

	// integral term quotient, shifted in 16-bit digits
	logic [63:0] iq_q;

	logic       out_valid_q;
	hpid_out_t  out_data_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// final step may load the output register
	logic out_fire;
	assign out_fire = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// accept-side
	logic        in_acc;
	logic [31:0] dt_in;
	assign in_acc = in_valid && !in_stall;
	assign dt_in  = in_data.now_ms - last_q;

	// error and gybe logic for S_ERR
	logic signed [15:0] pd, e, ae, ef, ec;
	logic               clr, pos, big, ngpos;
	logic [1:0]         nm;
	logic [31:0]        ngstart;
	always_comb begin
		pd  = wrap_dist(prev_hd_q, tgt_q);
		clr = (pd > RESET_ANGLE) || (pd < -RESET_ANGLE);
		e   = wrap_dist(hd_q, tgt_q);
		pos = (e > 16'sd0);
		ae  = (e < 16'sd0) ? -e : e;
		big = (ae > $signed({2'b0, thr_q}));
		nm      = mode_q;
		ngpos   = gpos_q;
		ngstart = gstart_q;
		if (big) begin
			if (nm == MODE_NORMAL) begin
				nm      = MODE_POT;
				ngstart = now_q;
				ngpos   = pos;
			end
			if ((pos == ngpos) && ((now_q - ngstart) > tmo_q)) begin
				nm = MODE_GYBE;
			end
		end else begin
			nm = MODE_NORMAL;
		end
		ef = e;
		if ((nm == MODE_GYBE) && (((e > 16'sd0) && ngpos) || ((e < 16'sd0) && !ngpos))) begin
			ef = -e;
		end
		if (ef > ERR_LIMIT) begin
			ec = ERR_LIMIT;
		end else if (ef < -ERR_LIMIT) begin
			ec = -ERR_LIMIT;
		end else begin
			ec = ef;
		end
	end

	// divide by 1000, one 16-bit digit: remainder:digit times reciprocal
	logic [25:0] rv;
	logic [15:0] rq;
	logic [25:0] rk;
	logic [9:0]  rr;
	assign rv = {rem_q[9:0], iq_q[63:48]};
	assign rq = prod_q[51:36];
	assign rk = {rq, 10'b0} - {6'b0, rq, 4'b0} - {7'b0, rq, 3'b0};
	assign rr = 10'(rv - rk);

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [47:0]        iabs;
	logic [31:0]        kabs;
	assign iabs = integral_q[47] ? (48'd0 - integral_q) : integral_q;
	assign kabs = gain_i_q[31] ? (32'd0 - gain_i_q) : gain_i_q;
	always_comb begin
		unique case (state_q)
			S_MUL_E: begin
				mul_a = 33'(err_q);
				mul_b = $signed({1'b0, dt_q});
			end
			S_MUL_P: begin
				mul_a = 33'(err_q);
				mul_b = 33'(gain_p_q);
			end
			S_MUL_D: begin
				mul_a = 33'(rate_q);
				mul_b = 33'(gain_d_q);
			end
			S_MUL_ILO: begin
				mul_a = $signed({9'b0, iabs[23:0]});
				mul_b = $signed({1'b0, kabs});
			end
			S_MUL_IHI: begin
				mul_a = $signed({9'b0, iabs[47:24]});
				mul_b = $signed({1'b0, kabs});
			end
			S_DIV_I: begin
				mul_a = $signed({7'b0, rv});
				mul_b = $signed({6'b0, RECIP_1000});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// product / 1024, toward zero
	logic signed [65:0] padj;
	logic signed [55:0] ptr;
	assign padj = prod_q + (prod_q[65] ? 66'sd1023 : 66'sd0);
	assign ptr  = 56'(padj >>> 10);

	// integral accumulate with 48-bit saturation
	logic signed [49:0] sum50;
	logic signed [47:0] sum_sat;
	assign sum50 = 50'(integral_q) + prod_q[49:0];
	always_comb begin
		if (sum50[49:47] == 3'b000 || sum50[49:47] == 3'b111) begin
			sum_sat = sum50[47:0];
		end else if (!sum50[49]) begin
			sum_sat = {1'b0, {47{1'b1}}};
		end else begin
			sum_sat = {1'b1, {47{1'b0}}};
		end
	end

	// rate dividend
	logic signed [14:0] diff;
	logic [14:0]        dmag;
	logic [24:0]        dnum;
	assign diff = 15'(err_q) - 15'(prev_err_q);
	assign dmag = diff[14] ? (15'd0 - diff) : diff;
	assign dnum = 25'(dmag) * 25'd1000;

	// integral limit compare
	logic signed [47:0] lim48;
	assign lim48 = $signed({9'b0, lim_q});

	// integral product assembly
	logic [80:0] ifull;
	logic        isat;
	assign ifull = ({24'b0, prod_q[56:0]} << 24) + {25'b0, plo_q};
	assign isat  = |ifull[80:63];

	// divider step
	logic [32:0] dstep;
	logic        dge;
	assign dstep = {rem_q, dq_q[52]};
	assign dge   = (dstep >= {1'b0, div_d_q});

	logic signed [55:0] iq;
	assign iq = $signed(iq_q[55:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			thr_q       <= 14'd1280;
			tmo_q       <= 32'd10000;
			last_q      <= '0;
			integral_q  <= '0;
			rate_q      <= '0;
			prev_err_q  <= '0;
			prev_hd_q   <= '0;
			gstart_q    <= '0;
			gpos_q      <= 1'b0;
			mode_q      <= MODE_NORMAL;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			cnt_q       <= '0;
			now_q       <= '0;
			dt_q        <= '0;
			hd_q        <= '0;
			tgt_q       <= '0;
			err_q       <= '0;
			nmode_q     <= MODE_NORMAL;
			rneg_q      <= 1'b0;
			lim_q       <= '0;
			prod_q      <= '0;
			plo_q       <= '0;
			acc_q       <= '0;
			ineg_q      <= 1'b0;
			dq_q        <= '0;
			rem_q       <= '0;
			div_d_q     <= '0;
			iq_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GAIN_P:   gain_p_q <= cfg_data;
					REG_GAIN_I:   gain_i_q <= cfg_data;
					REG_GAIN_D:   gain_d_q <= cfg_data;
					REG_GYBE_THR: thr_q    <= cfg_data[13:0];
					REG_GYBE_TMO: tmo_q    <= cfg_data;
					default: ;
				endcase
			end
			if (out_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			prod_q <= mul_p;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (dt_in >= MIN_DT_MS)) begin
						now_q   <= in_data.now_ms;
						hd_q    <= in_data.heading;
						tgt_q   <= in_data.target_heading;
						dt_q    <= dt_in;
						last_q  <= in_data.now_ms;
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					if (clr) begin
						integral_q <= '0;
						rate_q     <= '0;
					end
					err_q    <= ec[13:0];
					nmode_q  <= nm;
					gstart_q <= ngstart;
					gpos_q   <= ngpos;
					state_q  <= S_MUL_E;
				end
				S_MUL_E: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					integral_q <= sum_sat;
					rneg_q     <= diff[14];
					dq_q       <= {dnum[23:0], 29'b0};
					rem_q      <= '0;
					div_d_q    <= dt_q;
					cnt_q      <= 6'd24;
					state_q    <= S_DIV_R;
				end
				S_DIV_R, S_DIV_L: begin
					if (cnt_q != 6'd0) begin
						rem_q <= dge ? 32'(dstep - {1'b0, div_d_q}) : dstep[31:0];
						dq_q  <= {dq_q[51:0], dge};
						cnt_q <= cnt_q - 6'd1;
					end else if (state_q == S_DIV_R) begin
						rate_q <= rneg_q ? -$signed({14'b0, dq_q[17:0]})
							: $signed({14'b0, dq_q[17:0]});
						if (!gain_i_q[31] && (gain_i_q != 32'sd0)) begin
							dq_q    <= {ICLAMP_NUM, 14'b0};
							rem_q   <= '0;
							div_d_q <= gain_i_q;
							cnt_q   <= 6'd39;
							state_q <= S_DIV_L;
						end else begin
							state_q <= S_MUL_P;
						end
					end else begin
						lim_q   <= dq_q[38:0];
						state_q <= S_CLAMP_I;
					end
				end
				S_DIV_I: begin
					// even counts issue the multiply, odd counts take the digit
					if (cnt_q == 6'd0) begin
						acc_q   <= acc_q + (ineg_q ? -iq : iq);
						state_q <= S_OUT;
					end else begin
						if (cnt_q[0]) begin
							iq_q  <= {iq_q[47:0], rq};
							rem_q <= {22'b0, rr};
						end
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_CLAMP_I: begin
					if (integral_q > lim48) begin
						integral_q <= lim48;
					end else if (integral_q < -lim48) begin
						integral_q <= -lim48;
					end
					state_q <= S_MUL_P;
				end
				S_MUL_P: begin
					state_q <= S_MUL_D;
				end
				S_MUL_D: begin
					acc_q   <= ptr;
					state_q <= S_MUL_ILO;
				end
				S_MUL_ILO: begin
					acc_q   <= acc_q + ptr;
					ineg_q  <= integral_q[47] != gain_i_q[31];
					state_q <= S_MUL_IHI;
				end
				S_MUL_IHI: begin
					plo_q   <= prod_q[55:0];
					state_q <= S_ITERM;
				end
				S_ITERM: begin
					if (isat) begin
						acc_q   <= acc_q + (ineg_q ? -(56'sd1 <<< 50) : (56'sd1 <<< 50));
						state_q <= S_OUT;
					end else begin
						iq_q    <= {11'b0, ifull[62:10]};
						rem_q   <= '0;
						cnt_q   <= 6'd8;
						state_q <= S_DIV_I;
					end
				end
				S_OUT: begin
					if (out_fire) begin
						if (acc_q > TR_LIMIT) begin
							out_data_q.turn_rate <= 17'sd40960;
						end else if (acc_q < -TR_LIMIT) begin
							out_data_q.turn_rate <= -17'sd40960;
						end else begin
							out_data_q.turn_rate <= acc_q[16:0];
						end
						out_data_q.mode <= nmode_q;
						prev_err_q <= err_q;
						prev_hd_q  <= hd_q;
						mode_q     <= nmode_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sim/heading_pid_with_gybe_mode_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module heading_pid_with_gybe_mode_tb;
	import hpid_pkg::*;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// block ports
	logic        in_valid = 1'b0;
	logic        in_stall;
	hpid_in_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	hpid_out_t   out_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_GAIN_P;
	logic [31:0] cfg_data = '0;

	heading_pid_with_gybe_mode uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// controller registers as the predictor sees them
	longint      kp, ki, kd;
	logic [13:0] gthr;
	logic [31:0] gtmo;
	// controller state mirror
	logic [31:0] t_last;
	longint      integ;
	int          rate;
	int          perr;
	logic [14:0] phead;
	logic [31:0] g_start;
	bit          g_pos;
	logic [1:0]  cur_mode;

	hpid_out_t   exp_words[$];
	int          errors = 0;
	int unsigned cycles = 0;
	bit          quiet = 1'b0;     // last part: no idling
	bit          hold_long = 1'b0; // receiver hold-off request
	logic [31:0] clock_ms = 0;      // stimulus time base

	localparam longint I48_MAX = 64'sh7FFFFFFFFFFF;
	localparam longint I48_MIN = -I48_MAX - 1;

	function automatic int ang_dist(logic [14:0] o, logic [14:0] t);
		int unsigned r, m;
		int d;
		r = (o > t) ? o - t : t - o;
		m = r % 23040;
		if (m > 11520) begin
			d = 23040 - m;
			if (t > o) d = -d;
		end else begin
			d = m;
			if (o > t) d = -d;
		end
		return d;
	endfunction

	function automatic longint iterm(longint i, longint k);
		bit neg;
		longint unsigned a, b;
		longint q;
		neg = (i < 0) != (k < 0);
		a = (i < 0) ? -i : i;
		b = (k < 0) ? -k : k;
		if (a == 0 || b == 0) return 0;
		if (a > 64'h7FFFFFFFFFFFFFFF / b) q = 64'sd1 << 50;
		else q = longint'((a * b) / 64'd1024000);
		return neg ? -q : q;
	endfunction

	task automatic reg_mirror(logic [2:0] idx, logic [31:0] v);
		case (idx)
			REG_GAIN_P:   kp = longint'(signed'(v));
			REG_GAIN_I:   ki = longint'(signed'(v));
			REG_GAIN_D:   kd = longint'(signed'(v));
			REG_GYBE_THR: gthr = v[13:0];
			REG_GYBE_TMO: gtmo = v;
			default: ;
		endcase
	endtask

	// predicts the word for one accepted input; pushes it if dt >= 50
	task automatic predict_turn(hpid_in_t w);
		logic [31:0] dt;
		logic [1:0]  m;
		int          e, a;
		bit          pos;
		longint      s, tr, lim;
		hpid_out_t   r;
		dt = w.now_ms - t_last;
		if (dt < 50) return;
		t_last = w.now_ms;
		a = ang_dist(phead, w.target_heading);
		if (a > 2880 || a < -2880) begin
			integ = 0;
			rate = 0;
		end
		e = ang_dist(w.heading, w.target_heading);
		pos = e > 0;
		m = cur_mode;
		if (((e < 0) ? -e : e) > int'(gthr)) begin
			if (m == MODE_NORMAL) begin
				m = MODE_POT;
				g_start = w.now_ms;
				g_pos = pos;
			end
			if (pos == g_pos && (w.now_ms - g_start) > gtmo) m = MODE_GYBE;
		end else
			m = MODE_NORMAL;
		if (m == MODE_GYBE && ((e > 0 && g_pos) || (e < 0 && !g_pos))) e = -e;
		if (e > 5760) e = 5760;
		if (e < -5760) e = -5760;
		s = integ + longint'(e) * longint'({32'd0, dt});
		if (s > I48_MAX) s = I48_MAX;
		if (s < I48_MIN) s = I48_MIN;
		integ = s;
		rate = int'((longint'(e - perr) * 1000) / longint'({32'd0, dt}));
		if (ki > 0) begin
			lim = 64'sd419430400000 / ki;
			if (integ > lim) integ = lim;
			if (integ < -lim) integ = -lim;
		end
		tr = (longint'(e) * kp) / 1024 + iterm(integ, ki) + (longint'(rate) * kd) / 1024;
		if (tr > 40960) tr = 40960;
		if (tr < -40960) tr = -40960;
		perr = e;
		phead = w.heading;
		cur_mode = m;
		r.turn_rate = tr[16:0];
		r.mode = m;
		exp_words.push_back(r);
	endtask

	// configuration write, only while idle
	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_mirror(idx, v);
		@(posedge clk);
	endtask

	// wait for all expected words, then let the engine drain (dropped words)
	task automatic drain;
		while (exp_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// sender: hold one word until accepted, with random gaps
	task automatic send_word(hpid_in_t w);
		bit stalled;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		// stall is stable between edges; sample it ahead of each edge
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		predict_turn(w);
	endtask

	task automatic send_idle;
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver stall: random bursts, plus one long hold-off
	int stall_left = 0;
	always @(posedge clk) begin
		if (hold_long) out_stall <= 1'b1;
		else if (quiet) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 1) stall_left <= stall_left - 1;
		else if (stall_left == 1) begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(1, 11);
		end else out_stall <= 1'b0;
	end

	// long receiver hold-off counted here
	int hold_cnt = 0;
	bit hold_req = 1'b0;
	always @(posedge clk) begin
		if (hold_req && !hold_long && hold_cnt == 0) begin
			hold_long <= 1'b1;
			hold_cnt <= 600;
		end else if (hold_cnt > 1) hold_cnt <= hold_cnt - 1;
		else if (hold_cnt == 1) begin
			hold_cnt <= 0;
			hold_long <= 1'b0;
		end
	end

	// output checker: compare each word with the oldest expectation
	always @(posedge clk) begin
		hpid_out_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_words.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word tr=%0d mode=%0d",
					out_data.turn_rate, out_data.mode);
			end else begin
				x = exp_words.pop_front();
				if (x.turn_rate !== out_data.turn_rate || x.mode !== out_data.mode) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp tr=%0d mode=%0d got tr=%0d mode=%0d",
							x.turn_rate, x.mode, out_data.turn_rate, out_data.mode);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// directed rows: time step, heading, target
	typedef struct {
		logic [31:0] dt;
		logic [14:0] h;
		logic [14:0] t;
	} row_t;
	row_t rows[$];

	// random item with a mostly well-formed time step
	function automatic hpid_in_t rand_word(bit nice);
		hpid_in_t w;
		int k;
		k = $urandom_range(0, 9);
		if (!nice && k == 0) clock_ms = clock_ms + $urandom_range(0, 49);
		else if (k == 1) clock_ms = $urandom();
		else clock_ms = clock_ms + $urandom_range(50, 3000);
		w.now_ms = clock_ms;
		case ($urandom_range(0, 7))
			0: w.heading = 15'($urandom());        // any 15-bit value, wraps
			1: w.heading = 15'd23039;
			default: w.heading = 15'($urandom_range(0, 23039));
		endcase
		if ($urandom_range(0, 2) == 0)
			w.target_heading = 15'((w.heading + $urandom_range(0, 3000)) % 23040);
		else w.target_heading = 15'($urandom() % 32768);
		return w;
	endfunction

	task automatic rand_gains;
		case ($urandom_range(0, 3))
			0: reg_write(REG_GAIN_P, $urandom());
			default: reg_write(REG_GAIN_P, $urandom_range(0, 131072) - 65536);
		endcase
		case ($urandom_range(0, 3))
			0: reg_write(REG_GAIN_I, $urandom());
			1: reg_write(REG_GAIN_I, 32'h7FFFFFFF);
			default: reg_write(REG_GAIN_I, $urandom_range(0, 20000) - 5000);
		endcase
		case ($urandom_range(0, 3))
			0: reg_write(REG_GAIN_D, $urandom());
			default: reg_write(REG_GAIN_D, $urandom_range(0, 20000) - 10000);
		endcase
		reg_write(REG_GYBE_THR, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 11520));
		reg_write(REG_GYBE_TMO, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 5000));
	endtask

	initial begin
		hpid_in_t w;
		hpid_out_t ex;
		kp = 0; ki = 0; kd = 0; gthr = 1280; gtmo = 10000;
		t_last = 0; integ = 0; rate = 0; perr = 0; phead = 0;
		g_start = 0; g_pos = 0; cur_mode = MODE_NORMAL;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset all gains are zero: command is zero, mode read off
		w = '{now_ms: 32'd100, heading: 15'd0, target_heading: 15'd0};
		send_word(w);
		ex = exp_words[exp_words.size() - 1];
		if (ex.turn_rate !== 17'sd0 || ex.mode !== MODE_NORMAL) begin
			errors++;
			if (errors <= 10)
				$display("mismatch after reset: exp tr=0 mode=%0d got tr=%0d mode=%0d",
					MODE_NORMAL, ex.turn_rate, ex.mode);
		end
		clock_ms = 100;
		send_idle();
		drain();

		// extremes of the gains and registers
		reg_write(REG_GAIN_P, 32'h7FFFFFFF);
		reg_write(REG_GAIN_I, 32'h80000000);
		reg_write(REG_GAIN_D, 32'h00010000);
		reg_write(REG_GYBE_THR, 14'd11520);
		reg_write(REG_GYBE_TMO, 32'hFFFFFFFF);

		rows = '{
			'{50, 0, 23039}, '{49, 100, 200},  // early item dropped
			'{60, 23039, 0}, '{1000, 0, 11520}, '{70, 11520, 0},
			'{80, 32767, 0}, '{90, 0, 32767}, '{5000, 23039, 11519},
			'{50, 6000, 100}, '{32'hFFFFFF00, 100, 6000}, // time wrap
			'{300, 200, 200}, '{50, 32767, 32767}
		};
		foreach (rows[i]) begin
			clock_ms = clock_ms + rows[i].dt;
			send_word('{now_ms: clock_ms, heading: rows[i].h, target_heading: rows[i].t});
		end
		send_idle();
		drain();

		// gybe entry: small threshold and timeout, sustained large error
		reg_write(REG_GAIN_P, 32'h80000000);
		reg_write(REG_GAIN_I, 32'h00000001); // huge integral limit
		reg_write(REG_GAIN_D, 32'h80000000);
		reg_write(REG_GYBE_THR, 14'd0);
		reg_write(REG_GYBE_TMO, 32'd0);
		for (int i = 0; i < 8; i++) begin
			clock_ms = clock_ms + 100;
			send_word('{now_ms: clock_ms, heading: 15'd0, target_heading: 15'd9000});
		end
		send_idle();
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 8; ph++) begin
			rand_gains();
			if (ph == 3) hold_req = 1'b1;
			for (int i = 0; i < 100; i++) begin
				if (ph == 7) quiet = 1'b1;
				send_word(rand_word($urandom_range(0, 9) != 0));
				if (ph == 3 && i == 2) hold_req = 1'b0;
			end
			send_idle();
			drain();
		end

		drain();
		if (errors == 0 && exp_words.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
`default_nettype wire
